>>> design/vuo_pkg.sv
package vuo_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int NORM_FRAC_BITS  = 30;

  localparam int NUM_STAGES = 12;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int TOL_W      = 31;

  localparam int NUM_COORDS = 9;
  localparam int COORD_W    = 32;
  localparam int VOLUME_W   = 64;

  localparam int SUM_W  = 36;
  localparam int AREA_W = 68;

  localparam logic [DATA_W-1:0] NORMAL_ONE = DATA_W'(1) << NORM_FRAC_BITS;

  typedef enum logic [ADDR_W-3:0] {
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_OFFSET,
    REG_TOLERANCE
  } reg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] nx;
    logic [DATA_W-1:0] ny;
    logic [DATA_W-1:0] nz;
    logic [DATA_W-1:0] offset;
    logic [TOL_W-1:0]  tol;
  } cfg_t;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef logic [NUM_COORDS-1:0][COORD_W-1:0] vertex_set_t;

endpackage

>>> design/volume_under_overhang.sv
// Volume between one mesh triangle and the print plane.
// Input stream: one word per triangle, nine signed Q16.16 coordinates, vertex0
// x/y/z in the low bits up to vertex2 z. Output stream: one word per triangle,
// tdata the Q48.16 volume, tuser high when the volume was clamped to all ones.
// Plane normal (Q1.30), offset (Q16.16) and equal tolerance are set over the
// register port; change them only while no triangle is in flight.
// Throughput is one triangle per cycle while the receiver does not stall.
// Twelve register stages, the first loaded at the accepting edge, cover plane
// products and edge vectors, cross products, split normal products, the wide
// area multiply and a three-digit divide by three.
// Reset clears every stage valid bit and loads the default plane (z up through
// the origin, tolerance one LSB); no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps filling bubbles; input ready drops only once every stage
// from the output back to the input holds a word.
module volume_under_overhang import vuo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x, ..., vertex2_z
  input  logic [287:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // volume
  output logic [VOLUME_W-1:0] m_axis_tdata,
  // saturated
  output logic [0:0]          m_axis_tuser
);

  cfg_t              cfg;
  stage_en_t         stage_en;
  logic [NUM_STAGES-1:0] vld_d, vld_q;
  vertex_set_t       vtx;
  logic [SUM_W-1:0]  wsum;
  logic [AREA_W-1:0] area;
  logic              sat;

  vuo_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign stage_en[k] = m_axis_tready || !(&vld_q[NUM_STAGES-1:k]);
  end

  assign vld_d = (stage_en & {vld_q[NUM_STAGES-2:0], s_axis_tvalid}) | (~stage_en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign vtx = s_axis_tdata;

  vuo_dist u_dist (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .cfg_i (cfg),
    .vtx_i (vtx),
    .sum_o (wsum)
  );

  vuo_area u_area (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .cfg_i  (cfg),
    .vtx_i  (vtx),
    .area_o (area)
  );

  vuo_vol u_vol (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .area_i   (area),
    .sum_i    (wsum),
    .volume_o (m_axis_tdata),
    .sat_o    (sat)
  );

  assign s_axis_tready   = stage_en[0];
  assign m_axis_tvalid   = vld_q[NUM_STAGES-1];
  assign m_axis_tuser[0] = sat;

endmodule

>>> design/vuo_cfg.sv
module vuo_cfg import vuo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  output cfg_t              cfg_o
);

  logic [DATA_W-1:0] nx_q, ny_q, nz_q, off_q;
  logic [TOL_W-1:0]  tol_q;
  logic              wr_en;
  reg_idx_e          idx;

  function automatic logic [DATA_W-1:0] clamp_normal(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    priority if ($signed(v) > $signed(NORMAL_ONE)) begin
      r = NORMAL_ONE;
    end else if ($signed(v) < -$signed(NORMAL_ONE)) begin
      r = -NORMAL_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign idx      = reg_idx_e'(paddr_i[ADDR_W-1:2]);
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q  <= '0;
      ny_q  <= '0;
      nz_q  <= NORMAL_ONE;
      off_q <= '0;
      tol_q <= TOL_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_NORMAL_X:  nx_q  <= pwdata_i;
        REG_NORMAL_Y:  ny_q  <= pwdata_i;
        REG_NORMAL_Z:  nz_q  <= pwdata_i;
        REG_OFFSET:    off_q <= pwdata_i;
        REG_TOLERANCE: tol_q <= pwdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NORMAL_X:  prdata_o = nx_q;
      REG_NORMAL_Y:  prdata_o = ny_q;
      REG_NORMAL_Z:  prdata_o = nz_q;
      REG_OFFSET:    prdata_o = off_q;
      REG_TOLERANCE: prdata_o = DATA_W'(tol_q);
      default:       prdata_o = '0;
    endcase
  end

  assign cfg_o.nx     = clamp_normal(nx_q);
  assign cfg_o.ny     = clamp_normal(ny_q);
  assign cfg_o.nz     = clamp_normal(nz_q);
  assign cfg_o.offset = off_q;
  assign cfg_o.tol    = tol_q;

endmodule

>>> design/vuo_dist.sv
module vuo_dist import vuo_pkg::*; (
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  cfg_t             cfg_i,
  input  vertex_set_t      vtx_i,
  output logic [SUM_W-1:0] sum_o
);

  localparam int PROD_W  = 64;
  localparam int PLANE_W = 65;
  localparam int DIST_W  = 34;
  localparam logic [PLANE_W-1:0] RND_POS = PLANE_W'(1) << (NORM_FRAC_BITS - 1);
  localparam logic [PLANE_W-1:0] RND_NEG = RND_POS + PLANE_W'(1);

  logic [2:0][DATA_W-1:0] nrm;

  logic signed [PROD_W-1:0]  prod_d  [NUM_COORDS];
  logic signed [PROD_W-1:0]  prod_q  [NUM_COORDS];
  logic signed [PLANE_W-1:0] plane_d [3];
  logic signed [PLANE_W-1:0] plane_q [3];
  logic [DIST_W-1:0]         dist_d  [3];
  logic [DIST_W-1:0]         dist_q  [3];
  logic [DIST_W-1:0]         lo_d, hi_d, lo_q, hi_q;
  logic [SUM_W-1:0]          tot_d, tot_q;
  logic [DIST_W-1:0]         spread;
  logic [SUM_W-1:0]          wsum_d, wsum_q, wsum5_q, wsum6_q;

  assign nrm[0] = cfg_i.nx;
  assign nrm[1] = cfg_i.ny;
  assign nrm[2] = cfg_i.nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[3*i+j] = PROD_W'($signed(nrm[j])) * PROD_W'($signed(vtx_i[3*i+j]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      plane_d[i] = PLANE_W'(prod_q[3*i]) + PLANE_W'(prod_q[3*i+1])
                 + PLANE_W'(prod_q[3*i+2])
                 + (PLANE_W'($signed(cfg_i.offset)) <<< NORM_FRAC_BITS);
    end
  end

  always_comb begin
    logic [PLANE_W-1:0] sv;
    logic [PLANE_W-1:0] rnd;
    for (int i = 0; i < 3; i++) begin
      sv        = plane_q[i];
      rnd       = sv[PLANE_W-1] ? (~sv + RND_NEG) : (sv + RND_POS);
      dist_d[i] = rnd[DIST_W+NORM_FRAC_BITS-1:NORM_FRAC_BITS];
    end
  end

  always_comb begin
    lo_d = dist_q[0];
    hi_d = dist_q[0];
    for (int i = 1; i < 3; i++) begin
      if (dist_q[i] < lo_d) lo_d = dist_q[i];
      if (dist_q[i] > hi_d) hi_d = dist_q[i];
    end
    tot_d = SUM_W'(dist_q[0]) + SUM_W'(dist_q[1]) + SUM_W'(dist_q[2]);
  end

  always_comb begin
    spread = hi_q - lo_q;
    if (spread < DIST_W'(cfg_i.tol)) begin
      wsum_d = SUM_W'(lo_q) + (SUM_W'(lo_q) << 1);
    end else begin
      wsum_d = tot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) prod_q <= prod_d;
    if (en_i[1]) plane_q <= plane_d;
    if (en_i[2]) dist_q <= dist_d;
    if (en_i[3]) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      tot_q <= tot_d;
    end
    if (en_i[4]) wsum_q <= wsum_d;
    if (en_i[5]) wsum5_q <= wsum_q;
    if (en_i[6]) wsum6_q <= wsum5_q;
  end

  assign sum_o = wsum6_q;

endmodule

>>> design/vuo_area.sv
module vuo_area import vuo_pkg::*; (
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  cfg_t              cfg_i,
  input  vertex_set_t       vtx_i,
  output logic [AREA_W-1:0] area_o
);

  localparam int EDGE_W  = 33;
  localparam int MUL_W   = 66;
  localparam int CROSS_W = 67;
  localparam int SPLIT   = 33;
  localparam int PART_W  = 66;
  localparam int PSUM_W  = 68;
  localparam int DOT_W   = 100;
  localparam logic [DOT_W-1:0] RND_POS = DOT_W'(1) << (NORM_FRAC_BITS - 1);
  localparam logic [DOT_W-1:0] RND_NEG = RND_POS + DOT_W'(1);

  logic [2:0][DATA_W-1:0] nrm;

  logic signed [EDGE_W-1:0]  edge_d  [6];
  logic signed [EDGE_W-1:0]  edge_q  [6];
  logic signed [MUL_W-1:0]   mul_d   [6];
  logic signed [MUL_W-1:0]   mul_q   [6];
  logic signed [CROSS_W-1:0] cross_d [3];
  logic signed [CROSS_W-1:0] cross_q [3];
  logic signed [PART_W-1:0]  phi_d   [3];
  logic signed [PART_W-1:0]  phi_q   [3];
  logic signed [PART_W-1:0]  plo_d   [3];
  logic signed [PART_W-1:0]  plo_q   [3];
  logic signed [PSUM_W-1:0]  hsum_d, hsum_q, lsum_d, lsum_q;
  logic signed [DOT_W-1:0]   dot_d, dot_q;
  logic [DOT_W-1:0]          dot_rnd;
  logic [AREA_W-1:0]         area_d, area_q;

  assign nrm[0] = cfg_i.nx;
  assign nrm[1] = cfg_i.ny;
  assign nrm[2] = cfg_i.nz;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      edge_d[j]   = EDGE_W'($signed(vtx_i[3+j])) - EDGE_W'($signed(vtx_i[j]));
      edge_d[3+j] = EDGE_W'($signed(vtx_i[6+j])) - EDGE_W'($signed(vtx_i[j]));
    end
  end

  always_comb begin
    mul_d[0] = MUL_W'(edge_q[1]) * MUL_W'(edge_q[5]);
    mul_d[1] = MUL_W'(edge_q[2]) * MUL_W'(edge_q[4]);
    mul_d[2] = MUL_W'(edge_q[2]) * MUL_W'(edge_q[3]);
    mul_d[3] = MUL_W'(edge_q[0]) * MUL_W'(edge_q[5]);
    mul_d[4] = MUL_W'(edge_q[0]) * MUL_W'(edge_q[4]);
    mul_d[5] = MUL_W'(edge_q[1]) * MUL_W'(edge_q[3]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_d[i] = CROSS_W'(mul_q[2*i]) - CROSS_W'(mul_q[2*i+1]);
    end
  end

  always_comb begin
    logic [CROSS_W-1:0] cv;
    for (int i = 0; i < 3; i++) begin
      cv       = cross_q[i];
      phi_d[i] = PART_W'($signed(nrm[i]))
               * PART_W'($signed(cv[CROSS_W-1:SPLIT]));
      plo_d[i] = PART_W'($signed(nrm[i]))
               * PART_W'($signed({1'b0, cv[SPLIT-1:0]}));
    end
  end

  always_comb begin
    hsum_d = PSUM_W'(phi_q[0]) + PSUM_W'(phi_q[1]) + PSUM_W'(phi_q[2]);
    lsum_d = PSUM_W'(plo_q[0]) + PSUM_W'(plo_q[1]) + PSUM_W'(plo_q[2]);
  end

  assign dot_d = (DOT_W'(hsum_q) <<< SPLIT) + DOT_W'(lsum_q);

  always_comb begin
    logic [DOT_W-1:0] dv;
    dv      = dot_q;
    dot_rnd = dv[DOT_W-1] ? (~dv + RND_NEG) : (dv + RND_POS);
    area_d  = dot_rnd[AREA_W+NORM_FRAC_BITS-1:NORM_FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) edge_q <= edge_d;
    if (en_i[1]) mul_q <= mul_d;
    if (en_i[2]) cross_q <= cross_d;
    if (en_i[3]) begin
      phi_q <= phi_d;
      plo_q <= plo_d;
    end
    if (en_i[4]) begin
      hsum_q <= hsum_d;
      lsum_q <= lsum_d;
    end
    if (en_i[5]) dot_q <= dot_d;
    if (en_i[6]) area_q <= area_d;
  end

  assign area_o = area_q;

endmodule

>>> design/vuo_vol.sv
module vuo_vol import vuo_pkg::*; (
  input  logic                clk_i,
  input  stage_en_t           en_i,
  input  logic [AREA_W-1:0]   area_i,
  input  logic [SUM_W-1:0]    sum_i,
  output logic [VOLUME_W-1:0] volume_o,
  output logic                sat_o
);

  localparam int HALF_W    = AREA_W / 2;
  localparam int PP_W      = HALF_W + SUM_W;
  localparam int VSUM_W    = 105;
  localparam int VOL_SHIFT = 2 * COORD_FRAC_BITS + 1;
  localparam int DIG_W     = 22;
  localparam int QUOT_W    = 3 * DIG_W;
  localparam int RECIP_SH  = DIG_W + 3;
  localparam int CUR_W     = DIG_W + 2;
  localparam int RPROD_W   = CUR_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP3 = RECIP_SH'(((2 ** RECIP_SH) + 2) / 3);
  localparam logic [VSUM_W-1:0] VOL_ROUND = VSUM_W'(3) << (2 * COORD_FRAC_BITS);
  localparam logic [VSUM_W-1:0] SAT_LIMIT = VSUM_W'(3) << VOLUME_W;

  typedef struct packed {
    logic [DIG_W-1:0] q;
    logic [1:0]       r;
  } digit_t;

  function automatic digit_t div3_digit(input logic [1:0] rem, input logic [DIG_W-1:0] dig);
    logic [CUR_W-1:0]   cur;
    logic [RPROD_W-1:0] prod;
    logic [CUR_W-1:0]   back;
    digit_t             res;
    cur   = {rem, dig};
    prod  = RPROD_W'(cur) * RPROD_W'(RECIP3);
    res.q = prod[DIG_W+RECIP_SH-1:RECIP_SH];
    back  = cur - (CUR_W'(res.q) << 1) - CUR_W'(res.q);
    res.r = back[1:0];
    return res;
  endfunction

  logic [PP_W-1:0]          plo_d, plo_q, phi_d, phi_q;
  logic [VSUM_W-1:0]        vsum, yext;
  logic [QUOT_W-1:0]        quo_d, quo_q;
  logic                     sat8_d, sat8_q, sat9_q, sat10_q;
  digit_t                   dg9, dg10, dg11;
  logic [DIG_W-1:0]         q2_q, q2b_q, q1_q;
  logic [1:0]               r9_q, r10_q;
  logic [2*DIG_W-1:0]       ylo9_q;
  logic [DIG_W-1:0]         ylo10_q;
  logic [QUOT_W-1:0]        full;
  logic [VOLUME_W-1:0]      volume_d, volume_q;
  logic                     sat_q;

  assign plo_d = PP_W'(area_i[HALF_W-1:0]) * PP_W'(sum_i);
  assign phi_d = PP_W'(area_i[AREA_W-1:HALF_W]) * PP_W'(sum_i);

  always_comb begin
    vsum   = (VSUM_W'(phi_q) << HALF_W) + VSUM_W'(plo_q) + VOL_ROUND;
    yext   = vsum >> VOL_SHIFT;
    sat8_d = yext >= SAT_LIMIT;
    quo_d  = yext[QUOT_W-1:0];
  end

  assign dg9  = div3_digit(2'b00, quo_q[QUOT_W-1:2*DIG_W]);
  assign dg10 = div3_digit(r9_q, ylo9_q[2*DIG_W-1:DIG_W]);
  assign dg11 = div3_digit(r10_q, ylo10_q);

  always_comb begin
    full     = {q2b_q, q1_q, dg11.q};
    volume_d = sat10_q ? '1 : full[VOLUME_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (en_i[8]) begin
      quo_q  <= quo_d;
      sat8_q <= sat8_d;
    end
    if (en_i[9]) begin
      q2_q   <= dg9.q;
      r9_q   <= dg9.r;
      ylo9_q <= quo_q[2*DIG_W-1:0];
      sat9_q <= sat8_q;
    end
    if (en_i[10]) begin
      q2b_q   <= q2_q;
      q1_q    <= dg10.q;
      r10_q   <= dg10.r;
      ylo10_q <= ylo9_q[DIG_W-1:0];
      sat10_q <= sat9_q;
    end
    if (en_i[11]) begin
      volume_q <= volume_d;
      sat_q    <= sat10_q;
    end
  end

  assign volume_o = volume_q;
  assign sat_o    = sat_q;

endmodule

>>> design/vuo_checker.sv
module vuo_checker import vuo_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [VOLUME_W-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> &m_axis_tdata)
    else $error("clamped volume is not all ones");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with a free output stage");

endmodule

bind volume_under_overhang vuo_checker u_vuo_checker (.*);

>>> bench/tb.sv
module tb;
  import vuo_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_TRIANGLES = 175;

  typedef logic signed [127:0] exact_t;
  typedef logic [NUM_COORDS*COORD_W-1:0] facet_t;

  typedef struct packed {
    logic [VOLUME_W-1:0] volume;
    logic                saturated;
  } volume_res_t;

  localparam exact_t UNIT_Q30    = exact_t'(1) <<< NORM_FRAC_BITS;
  localparam exact_t HALF_Q30    = exact_t'(1) <<< (NORM_FRAC_BITS - 1);
  localparam exact_t VOL_ROUND   = exact_t'(3) <<< (2 * COORD_FRAC_BITS);
  localparam exact_t VOL_DIVISOR = exact_t'(6) <<< (2 * COORD_FRAC_BITS);

  localparam logic [COORD_W-1:0] C_MAX   = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] C_MIN   = 32'h8000_0000;
  localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x, ..., vertex2_z
  facet_t              s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // volume
  logic [VOLUME_W-1:0] m_axis_tdata;
  // saturated
  logic [0:0]          m_axis_tuser;

  logic signed [DATA_W-1:0] plane_nx  = '0;
  logic signed [DATA_W-1:0] plane_ny  = '0;
  logic signed [DATA_W-1:0] plane_nz  = NORMAL_ONE;
  logic signed [DATA_W-1:0] plane_off = '0;
  logic [TOL_W-1:0]         eq_tol    = TOL_W'(1);

  volume_res_t volume_q[$];
  int error_count    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int idle_cycles    = 0;

  volume_under_overhang u_top (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic exact_t clamp_unit(logic signed [DATA_W-1:0] raw);
    exact_t v;
    v = raw;
    if (v > UNIT_Q30) begin
      v = UNIT_Q30;
    end else if (v < -UNIT_Q30) begin
      v = -UNIT_Q30;
    end
    return v;
  endfunction

  function automatic volume_res_t predict_volume(facet_t facet);
    exact_t p [NUM_COORDS];
    exact_t d [3];
    exact_t nx, ny, nz, off, tol, lo, hi, sum;
    exact_t e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz, dot, area, vol;
    volume_res_t res;
    nx  = clamp_unit(plane_nx);
    ny  = clamp_unit(plane_ny);
    nz  = clamp_unit(plane_nz);
    off = plane_off;
    tol = eq_tol;
    for (int i = 0; i < NUM_COORDS; i++) begin
      p[i] = $signed(facet[COORD_W*i +: COORD_W]);
    end
    for (int v = 0; v < 3; v++) begin
      d[v] = nx * p[3*v] + ny * p[3*v+1] + nz * p[3*v+2] + (off <<< NORM_FRAC_BITS);
      if (d[v] < 0) begin
        d[v] = -d[v];
      end
      d[v] = (d[v] + HALF_Q30) >>> NORM_FRAC_BITS;
    end
    lo = d[0];
    hi = d[0];
    for (int v = 1; v < 3; v++) begin
      if (d[v] < lo) lo = d[v];
      if (d[v] > hi) hi = d[v];
    end
    sum = (hi - lo < tol) ? 3 * lo : d[0] + d[1] + d[2];
    e1x = p[3] - p[0];
    e1y = p[4] - p[1];
    e1z = p[5] - p[2];
    e2x = p[6] - p[0];
    e2y = p[7] - p[1];
    e2z = p[8] - p[2];
    cx  = e1y * e2z - e1z * e2y;
    cy  = e1z * e2x - e1x * e2z;
    cz  = e1x * e2y - e1y * e2x;
    dot = cx * nx + cy * ny + cz * nz;
    if (dot < 0) begin
      dot = -dot;
    end
    area = (dot + HALF_Q30) >>> NORM_FRAC_BITS;
    vol  = (area * sum + VOL_ROUND) / VOL_DIVISOR;
    res.saturated = (vol[127:VOLUME_W] != '0);
    res.volume    = res.saturated ? '1 : vol[VOLUME_W-1:0];
    return res;
  endfunction

  function automatic facet_t make_facet(input logic [COORD_W-1:0] x0, y0, z0,
                                        x1, y1, z1, x2, y2, z2);
    return {z2, y2, x2, z1, y1, x1, z0, y0, x0};
  endfunction

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      default: return ONE_Q16;
    endcase
  endfunction

  // Mostly small mesh-like triangles, with flat, degenerate, extreme and raw ones mixed in.
  function automatic facet_t random_facet();
    facet_t f;
    logic [COORD_W-1:0] base [3];
    logic [COORD_W-1:0] coord;
    int kind;
    kind = $urandom_range(9);
    for (int a = 0; a < 3; a++) begin
      base[a] = $urandom_range(32'h0200_0000) - 32'h0100_0000;
    end
    for (int i = 0; i < NUM_COORDS; i++) begin
      case (kind)
        0, 1: coord = $urandom;
        9: coord = pick_extreme();
        default: coord = base[i%3] + $urandom_range(32'h0020_0000) - 32'h0010_0000;
      endcase
      if ((kind == 6 || kind == 7) && i % 3 == 2) begin
        coord = base[2] + $urandom_range(3);
      end
      f[COORD_W*i +: COORD_W] = coord;
    end
    if (kind == 8) begin
      case ($urandom_range(2))
        0: f[3*COORD_W +: 3*COORD_W] = f[0 +: 3*COORD_W];
        1: f[6*COORD_W +: 3*COORD_W] = f[3*COORD_W +: 3*COORD_W];
        default: begin
          for (int a = 0; a < 3; a++) begin
            f[COORD_W*(6+a) +: COORD_W] = 2 * f[COORD_W*(3+a) +: COORD_W]
                                          - f[COORD_W*a +: COORD_W];
          end
        end
      endcase
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic set_pace(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    logic [DATA_W-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_NORMAL_X:  plane_nx  = value;
      REG_NORMAL_Y:  plane_ny  = value;
      REG_NORMAL_Z:  plane_nz  = value;
      REG_OFFSET:    plane_off = value;
      REG_TOLERANCE: eq_tol    = value[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    stored = (idx == REG_TOLERANCE) ? DATA_W'(value[TOL_W-1:0]) : value;
    if (readback !== stored) begin
      report_mismatch($sformatf("register %s reads %h, expected %h",
                                idx.name(), readback, stored));
    end
    @(negedge clk_i);
  endtask

  task automatic write_plane(input logic [DATA_W-1:0] nx, ny, nz, off, tol);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_OFFSET, off);
    write_reg(REG_TOLERANCE, tol);
  endtask

  task automatic send_facet(input facet_t facet);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= facet;
    do @(posedge clk_i); while (!s_axis_tready);
    volume_q.push_back(predict_volume(facet));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (volume_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_default_plane();
    set_pace(0, 0);
    send_facet('0);
    send_facet(make_facet(0, 0, 5*ONE_Q16, ONE_Q16, 0, 5*ONE_Q16, 0, ONE_Q16, 5*ONE_Q16));
    send_facet(make_facet(0, 0, ONE_Q16, 2*ONE_Q16, 0, 2*ONE_Q16, 0, 2*ONE_Q16, 3*ONE_Q16));
    send_facet(make_facet(0, 0, -3*ONE_Q16, 4*ONE_Q16, 0, -ONE_Q16,
                          0, 4*ONE_Q16, -2*ONE_Q16));
    send_facet(make_facet(0, 0, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16,
                          2*ONE_Q16, 2*ONE_Q16, ONE_Q16));
    send_facet(make_facet(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    send_facet(make_facet(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, '1, C_MAX, C_MIN, 0));
    drain();
  endtask

  task automatic test_normal_clamp();
    set_pace(0, 0);
    write_plane(32'h7FFF_FFFF, 32'h4000_0000, 32'h5000_0000, 32'h7FFF_FFFF, 1);
    send_facet(make_facet(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX));
    send_facet(make_facet(0, 0, 5*ONE_Q16, ONE_Q16, 0, 5*ONE_Q16, 0, ONE_Q16, 5*ONE_Q16));
    drain();
    write_plane(32'h8000_0000, 32'hC000_0000, 32'h8000_0001, 32'h8000_0000, 1);
    send_facet(make_facet(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX));
    send_facet(make_facet(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN));
    send_facet(make_facet(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    drain();
  endtask

  task automatic test_tolerance_edges();
    set_pace(0, 0);
    write_plane(0, 0, NORMAL_ONE, 0, 0);
    send_facet(make_facet(0, 0, 5*ONE_Q16, ONE_Q16, 0, 5*ONE_Q16, 0, ONE_Q16, 5*ONE_Q16));
    send_facet(make_facet(0, 0, 5*ONE_Q16, ONE_Q16, 0, 5*ONE_Q16 + 1,
                          0, ONE_Q16, 5*ONE_Q16));
    drain();
    write_reg(REG_TOLERANCE, 2);
    send_facet(make_facet(0, 0, 5*ONE_Q16, ONE_Q16, 0, 5*ONE_Q16 + 1,
                          0, ONE_Q16, 5*ONE_Q16));
    send_facet(make_facet(0, 0, ONE_Q16, 2*ONE_Q16, 0, 2*ONE_Q16, 0, 2*ONE_Q16, 3*ONE_Q16));
    drain();
    write_plane(0, 0, -NORMAL_ONE, 32'h8000_0000, 32'hFFFF_FFFF);
    send_facet(make_facet(0, 0, ONE_Q16, 2*ONE_Q16, 0, 2*ONE_Q16, 0, 2*ONE_Q16, 3*ONE_Q16));
    send_facet(make_facet(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    drain();
    write_plane(0, 0, 0, C_MAX, 1);
    send_facet(make_facet(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    drain();
  endtask

  task automatic random_plane();
    logic [DATA_W-1:0] n [3];
    logic [DATA_W-1:0] off, tol;
    int axis;
    axis = $urandom_range(2);
    case ($urandom_range(3))
      0: begin
        for (int a = 0; a < 3; a++) n[a] = '0;
        n[axis] = $urandom_range(1) ? NORMAL_ONE : -NORMAL_ONE;
      end
      1: for (int a = 0; a < 3; a++) n[a] = $urandom_range(32'h8000_0000) - 32'h4000_0000;
      2: for (int a = 0; a < 3; a++) n[a] = $urandom;
      default: begin
        for (int a = 0; a < 3; a++) n[a] = $urandom_range(32'h0010_0000) - 32'h0008_0000;
        n[axis] = NORMAL_ONE - $urandom_range(32'h0010_0000);
      end
    endcase
    off = $urandom_range(1) ? $urandom : $urandom_range(32'h0200_0000) - 32'h0100_0000;
    case ($urandom_range(3))
      0: tol = '0;
      1: tol = $urandom_range(16);
      2: tol = '1;
      default: tol = $urandom;
    endcase
    write_plane(n[0], n[1], n[2], off, tol);
  endtask

  task automatic test_random_mesh();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_plane();
      case (phase % 4)
        0: set_pace(0, 0);
        1: set_pace(81, 0);
        2: set_pace(0, 81);
        default: set_pace(32, 32);
      endcase
      repeat (PHASE_TRIANGLES) send_facet(random_facet());
      drain();
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    volume_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (volume_q.size() == 0) begin
        report_mismatch("result word with no triangle pending");
      end else begin
        want = volume_q.pop_front();
        if (m_axis_tdata !== want.volume) begin
          report_mismatch($sformatf("volume %h, expected %h", m_axis_tdata, want.volume));
        end
        if (m_axis_tuser[0] !== want.saturated) begin
          report_mismatch($sformatf("saturated %b, expected %b",
                                    m_axis_tuser[0], want.saturated));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_plane();
    test_normal_clamp();
    test_tolerance_edges();
    test_random_mesh();
    drain();
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
